[hdl/battery_soc_estimator_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the battery SOC estimator
// Shared wrappers for the concurrent checks at the end of each module.
// ----------------------------------------------------------------------------
`ifndef BATTERY_SOC_ESTIMATOR_UNIT_DEFINES_SVH
`define BATTERY_SOC_ESTIMATOR_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define BSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bse_pkg.sv]
// ----------------------------------------------------------------------------
// bse_pkg
// Types, register codes and reset values of the battery SOC estimator.
// ----------------------------------------------------------------------------
package bse_pkg;

	localparam int AVG_COUNT_DEF     = 20;
	localparam int TABLE_ENTRIES_DEF = 101;

	localparam int SUM_W = 21;   // running sum
	localparam int CNT_W = 6;    // sample counter, also divider divisor width
	localparam int MV_W  = 16;
	localparam int SOC_W = 7;
	localparam int IDX_W = 3;    // config register index

	localparam logic [IDX_W-1:0] REG_SCALE_GAIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_CELL_COUNT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_CELL_OVER    = 3'd2;
	localparam logic [IDX_W-1:0] REG_CELL_UNDER   = 3'd3;
	localparam logic [IDX_W-1:0] REG_ERR_CHECK_EN = 3'd4;

	localparam logic [15:0] RST_SCALE_GAIN   = 16'd256;
	localparam logic [3:0]  RST_CELL_COUNT   = 4'd6;
	localparam logic [15:0] RST_CELL_OVER    = 16'd2500;
	localparam logic [15:0] RST_CELL_UNDER   = 16'd1500;
	localparam logic        RST_ERR_CHECK_EN = 1'b1;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TABLE  = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [11:0] adc_sample;
		logic        motor_busy;
		logic [6:0]  table_index;
		logic [15:0] table_value;
	} in_word_t;

	typedef struct packed {
		logic [SOC_W-1:0] soc_percent;
		logic             battery_error;
		logic [MV_W-1:0]  average_mv;
	} out_word_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

[hdl/battery_soc_estimator_unit.sv]
// ----------------------------------------------------------------------------
// battery_soc_estimator_unit
// State of charge from an averaged pack voltage and an OCV lookup table.
// ----------------------------------------------------------------------------
// One word at a time. A table word writes one OCV entry and is done in the
// cycle it is taken (an index past the table end is dropped); busy samples
// are dropped the same way. Any other sample runs to a single result word,
// passing through the averaging state when it closes an averaging window;
// the next word is taken once the sequencer is back in idle. The window
// average, sum / AVG_COUNT, is a reciprocal multiply in its own state. The
// cell split, average / cell_count, runs on a restoring divider (one quotient
// bit per cycle over a 21-bit dividend); the nearest-entry search then walks
// the OCV table through its single registered read port, one entry per cycle.
// A zero average returns without the divide or the walk, and an implausible
// cell voltage without the walk. The OCV table must be fully written before
// the first sample; entries are not cleared by reset. A finished word waits
// in the output register, and table words are still taken while it waits; a
// sample that finishes while that register is still full holds until it
// frees.
// ----------------------------------------------------------------------------
`include "battery_soc_estimator_unit_defines.svh"

module battery_soc_estimator_unit #(
	parameter int AVG_COUNT     = bse_pkg::AVG_COUNT_DEF,
	parameter int TABLE_ENTRIES = bse_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  bse_pkg::in_word_t          in_word,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output bse_pkg::out_word_t         out_word,
	// config write port
	input  logic                       cfg_we,
	input  logic [bse_pkg::IDX_W-1:0]  cfg_index,
	input  logic [15:0]                cfg_data
);

	localparam int AW    = $clog2(TABLE_ENTRIES);
	localparam int SUM_W = bse_pkg::SUM_W;
	localparam int CNT_W = bse_pkg::CNT_W;
	localparam int MV_W  = bse_pkg::MV_W;
	localparam int SOC_W = bse_pkg::SOC_W;

	// sum / AVG_COUNT as (sum * ceil(2^SH / AVG_COUNT)) >> SH; the rounding
	// error times any SUM_W-bit sum stays below 2^SH, so the quotient is exact
	localparam int RECIP_SH = SUM_W + $clog2(AVG_COUNT);
	localparam int RCP_W    = RECIP_SH + 1;
	localparam int PROD_W   = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] AVG_RECIP =
		RCP_W'(((longint'(1) << RECIP_SH) + AVG_COUNT - 1) / AVG_COUNT);

	// sequencer states
	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_MUL       = 4'd1;  // gain product
	localparam logic [3:0] ST_ACC       = 4'd2;  // saturate and accumulate
	localparam logic [3:0] ST_AVG       = 4'd3;  // sum / count by reciprocal
	localparam logic [3:0] ST_CHK       = 4'd4;  // zero average, start cell divide
	localparam logic [3:0] ST_CELL_WAIT = 4'd5;  // average / cell_count
	localparam logic [3:0] ST_RANGE     = 4'd6;  // plausibility, first table read
	localparam logic [3:0] ST_SCAN      = 4'd7;  // nearest-entry walk
	localparam logic [3:0] ST_DONE      = 4'd8;  // clamp at table ends, else nearest entry
	localparam logic [3:0] ST_OUT       = 4'd9;  // hand result to output reg

	// config registers
	logic [15:0] gain_q;
	logic [3:0]  cell_cnt_q;
	logic [15:0] over_q, under_q;
	logic        err_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= bse_pkg::RST_SCALE_GAIN;
			cell_cnt_q <= bse_pkg::RST_CELL_COUNT;
			over_q     <= bse_pkg::RST_CELL_OVER;
			under_q    <= bse_pkg::RST_CELL_UNDER;
			err_en_q   <= bse_pkg::RST_ERR_CHECK_EN;
		end else if (cfg_we) begin
			case (cfg_index)
				bse_pkg::REG_SCALE_GAIN:   gain_q     <= cfg_data;
				bse_pkg::REG_CELL_COUNT:   cell_cnt_q <= cfg_data[3:0];
				bse_pkg::REG_CELL_OVER:    over_q     <= cfg_data;
				bse_pkg::REG_CELL_UNDER:   under_q    <= cfg_data;
				bse_pkg::REG_ERR_CHECK_EN: err_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// state
	logic [3:0]       state_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MV_W-1:0]  avg_q;
	logic [SOC_W-1:0] soc_q;
	logic             err_q;

	// per-item working registers
	logic [11:0]      adc_q;
	logic [27:0]      prod_s1;
	logic [SUM_W-1:0] win_sum_s1;
	logic [MV_W-1:0]  cell_q;
	logic [AW-1:0]    ridx_q;
	logic [SOC_W-1:0] best_q;
	logic [MV_W-1:0]  bestd_q;
	logic [MV_W-1:0]  t0_q, tlast_q;

	logic out_valid_q;
	bse_pkg::out_word_t out_word_q;

	// OCV table
	logic [MV_W-1:0] ocv_mem [TABLE_ENTRIES];
	logic [MV_W-1:0] rd_data_q;
	logic            wr_en, rd_en;
	logic [AW-1:0]   wr_addr, rd_addr;

	// divider
	bse_pkg::div_req_t div_req;
	bse_pkg::div_rsp_t div_rsp;

	bse_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// accumulate datapath
	logic             accept;
	logic [MV_W-1:0]  scaled;
	logic [SUM_W-1:0] sum_new;
	logic [CNT_W-1:0] cnt_new;
	logic             avg_due;
	logic [PROD_W-1:0] avg_prod;
	logic [CNT_W-1:0] cell_div;
	logic [MV_W-1:0]  diff;
	logic             ridx_last;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign scaled  = (|prod_s1[27:24]) ? '1 : prod_s1[23:8];
	assign sum_new = SUM_W'(sum_q + SUM_W'(scaled));
	assign cnt_new = CNT_W'(cnt_q + 1'b1);
	assign avg_due = cnt_new >= CNT_W'(AVG_COUNT);

	// closed window sum times the reciprocal of the count
	assign avg_prod = PROD_W'(win_sum_s1) * PROD_W'(AVG_RECIP);

	// zero cells behaves as one
	assign cell_div = (cell_cnt_q == '0) ? CNT_W'(1) : CNT_W'(cell_cnt_q);

	assign diff      = (cell_q >= rd_data_q) ? MV_W'(cell_q - rd_data_q)
	                                         : MV_W'(rd_data_q - cell_q);
	assign ridx_last = ridx_q == AW'(TABLE_ENTRIES - 1);

	always_comb begin
		div_req.start    = (state_q == ST_CHK) && (avg_q != '0);
		div_req.dividend = SUM_W'(avg_q);
		div_req.divisor  = cell_div;
	end

	// table port: writes from the input channel, reads from the walk
	assign wr_en   = accept && (in_word.kind == bse_pkg::KIND_TABLE)
	                 && ({1'b0, in_word.table_index} < 8'(TABLE_ENTRIES));
	assign wr_addr = in_word.table_index[AW-1:0];
	assign rd_en   = (state_q == ST_RANGE) || ((state_q == ST_SCAN) && !ridx_last);
	assign rd_addr = (state_q == ST_RANGE) ? '0 : AW'(ridx_q + 1'b1);

	always_ff @(posedge clk) begin
		if (wr_en)
			ocv_mem[wr_addr] <= in_word.table_value;
		if (rd_en)
			rd_data_q <= ocv_mem[rd_addr];
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			cnt_q   <= '0;
			avg_q   <= '0;
			soc_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && in_word.kind == bse_pkg::KIND_SAMPLE && !in_word.motor_busy)
						state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (avg_due) begin
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_AVG;
					end else begin
						sum_q   <= sum_new;
						cnt_q   <= cnt_new;
						state_q <= ST_CHK;
					end
				end
				ST_AVG: begin
					avg_q   <= avg_prod[RECIP_SH +: MV_W];
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (avg_q == '0) begin
						soc_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_CELL_WAIT;
					end
				end
				ST_CELL_WAIT: begin
					if (div_rsp.done)
						state_q <= ST_RANGE;
				end
				ST_RANGE: begin
					if (cell_q > over_q || cell_q < under_q) begin
						// implausible: SOC kept
						if (err_en_q)
							err_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ridx_last)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cell_q <= t0_q)
						soc_q <= '0;
					else if (cell_q >= tlast_q)
						soc_q <= SOC_W'(TABLE_ENTRIES - 1);
					else
						soc_q <= best_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working payload registers
	always_ff @(posedge clk) begin
		if (accept)
			adc_q <= in_word.adc_sample;
		if (state_q == ST_MUL)
			prod_s1 <= 28'(adc_q) * 28'(gain_q);
		if (state_q == ST_ACC)
			win_sum_s1 <= sum_new;
		if (state_q == ST_CELL_WAIT && div_rsp.done)
			cell_q <= div_rsp.quotient[MV_W-1:0];
		if (state_q == ST_RANGE)
			ridx_q <= '0;
		if (state_q == ST_SCAN) begin
			ridx_q <= AW'(ridx_q + 1'b1);
			// strict compare keeps the lowest index on ties
			if (ridx_q == '0) begin
				t0_q    <= rd_data_q;
				best_q  <= '0;
				bestd_q <= diff;
			end else if (diff < bestd_q) begin
				best_q  <= SOC_W'(ridx_q);
				bestd_q <= diff;
			end
			if (ridx_last)
				tlast_q <= rd_data_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_word_q.soc_percent   <= soc_q;
			out_word_q.battery_error <= err_q;
			out_word_q.average_mv    <= avg_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`BSE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q < CNT_W'(AVG_COUNT), "sample counter passed limit")
	`BSE_ASSERT_NOW(a_div_done_wait, div_rsp.done,
		state_q == ST_CELL_WAIT, "divider result with no taker")
	`BSE_ASSERT_NOW(a_scan_range, state_q == ST_SCAN,
		ridx_q <= AW'(TABLE_ENTRIES - 1), "table walk past last entry")
	`BSE_ASSERT_NOW(a_out_from_seq, $rose(out_valid_q),
		$past(state_q) == ST_OUT, "result word not from sequencer")
	`BSE_ASSERT_NOW(a_soc_bound, out_valid_q,
		out_word_q.soc_percent <= SOC_W'(TABLE_ENTRIES - 1), "SOC beyond table")

endmodule

[hdl/bse_divider.sv]
// ----------------------------------------------------------------------------
// bse_divider
// Restoring divider, one quotient bit per cycle, for the cell voltage split.
// ----------------------------------------------------------------------------
`include "battery_soc_estimator_unit_defines.svh"

module bse_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  bse_pkg::div_req_t req,
	output bse_pkg::div_rsp_t rsp
);

	localparam int W  = bse_pkg::SUM_W;
	localparam int DW = bse_pkg::CNT_W;
	localparam int CW = $clog2(W);

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q, div_q;
	logic [W-1:0]  quo_q;
	logic [DW:0]   trial, diff;
	logic          ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= CW'(cnt_q + 1'b1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`BSE_ASSERT_NOW(a_div_start_idle, req.start, !busy_q, "divider started while busy")
	`BSE_ASSERT_NOW(a_div_nonzero, req.start, req.divisor != '0, "divide by zero requested")
	`BSE_ASSERT_NOW(a_div_rem_bound, busy_q, rem_q < div_q, "partial remainder out of range")
	`BSE_ASSERT_NEXT(a_div_done_once, done_q, !done_q && !busy_q, "done not a single pulse")

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for battery_soc_estimator_unit. A scoreboard class
// mirrors the averaging, the cell split and the OCV nearest-entry search, and
// checks every result word in order. The run steps through a series of
// register settings: defaults, gain and cell-count extremes, zero gain, a zero
// cell count and random settings, sometimes with inverted limits. Each
// setting gets a freshly loaded OCV table, either a ramp or a coarse
// staircase full of ties. Both handshakes idle at random.
// ----------------------------------------------------------------------------
import bse_pkg::*;

class soc_scoreboard;
	// register copy
	logic [15:0]      gain;
	logic [3:0]       cells;
	logic [15:0]      over_mv;
	logic [15:0]      under_mv;
	logic             chk_en;
	// estimator state
	logic [SUM_W-1:0] acc_sum;
	logic [CNT_W-1:0] acc_cnt;
	logic [MV_W-1:0]  avg_mv;
	logic [SOC_W-1:0] soc;
	logic             err;
	logic [15:0]      ocv [TABLE_ENTRIES_DEF];
	out_word_t        expected_q[$];
	// bookkeeping
	int               mismatches;
	int               checked;
	int               n_zero, n_implausible, n_low, n_high, n_nearest, n_dropped;

	function new();
		int i;
		gain          = RST_SCALE_GAIN;
		cells         = RST_CELL_COUNT;
		over_mv       = RST_CELL_OVER;
		under_mv      = RST_CELL_UNDER;
		chk_en        = RST_ERR_CHECK_EN;
		acc_sum       = '0;
		acc_cnt       = '0;
		avg_mv        = '0;
		soc           = '0;
		err           = 1'b0;
		mismatches    = 0;
		checked       = 0;
		n_zero        = 0;
		n_implausible = 0;
		n_low         = 0;
		n_high        = 0;
		n_nearest     = 0;
		n_dropped     = 0;
		for (i = 0; i < TABLE_ENTRIES_DEF; i++)
			ocv[i] = '0;
	endfunction

	function void write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
		case (idx)
			REG_SCALE_GAIN:   gain = val;
			REG_CELL_COUNT:   cells = val[3:0];
			REG_CELL_OVER:    over_mv = val;
			REG_CELL_UNDER:   under_mv = val;
			REG_ERR_CHECK_EN: chk_en = val[0];
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// accepted input word: update state, queue the result it causes
	function void note_input(in_word_t w);
		logic [27:0]      prod;
		logic [15:0]      scaled;
		logic [3:0]       divisor;
		logic [15:0]      cell_mv;
		logic [15:0]      d, best_d;
		logic [SOC_W-1:0] best;
		out_word_t        r;
		int               i;
		if (w.kind == KIND_TABLE) begin
			if (w.table_index < TABLE_ENTRIES_DEF)
				ocv[w.table_index] = w.table_value;
			else
				n_dropped++;
			return;
		end
		if (w.motor_busy) begin
			n_dropped++;
			return;
		end
		prod    = w.adc_sample * gain;
		scaled  = (prod[27:24] != 0) ? 16'hFFFF : prod[23:8];
		acc_sum = acc_sum + scaled;
		acc_cnt = acc_cnt + 1'b1;
		if (acc_cnt >= AVG_COUNT_DEF) begin
			avg_mv  = acc_sum / acc_cnt;
			acc_cnt = '0;
			acc_sum = '0;
		end
		if (avg_mv == 0) begin
			soc = '0;
			n_zero++;
		end else begin
			divisor = (cells == 0) ? 4'd1 : cells;
			cell_mv = avg_mv / divisor;
			if (cell_mv > over_mv || cell_mv < under_mv) begin
				if (chk_en)
					err = 1'b1;
				n_implausible++;
			end else if (cell_mv <= ocv[0]) begin
				soc = '0;
				n_low++;
			end else if (cell_mv >= ocv[TABLE_ENTRIES_DEF-1]) begin
				soc = SOC_W'(TABLE_ENTRIES_DEF - 1);
				n_high++;
			end else begin
				best   = '0;
				best_d = (cell_mv >= ocv[0]) ? cell_mv - ocv[0] : ocv[0] - cell_mv;
				for (i = 1; i < TABLE_ENTRIES_DEF; i++) begin
					d = (cell_mv >= ocv[i]) ? cell_mv - ocv[i] : ocv[i] - cell_mv;
					if (d < best_d) begin
						best_d = d;
						best   = SOC_W'(i);
					end
				end
				soc = best;
				n_nearest++;
			end
		end
		r.soc_percent   = soc;
		r.battery_error = err;
		r.average_mv    = avg_mv;
		expected_q.push_back(r);
	endfunction

	task report_mismatch(string what, int got, int want);
		if (mismatches < 40)
			$display("ERROR: result %0d %s: got %0d, expected %0d", checked, what, got, want);
		mismatches++;
	endtask

	task check_result(out_word_t got);
		out_word_t want;
		checked++;
		if (expected_q.size() == 0) begin
			report_mismatch("unexpected word, soc_percent", int'(got.soc_percent), -1);
			return;
		end
		want = expected_q.pop_front();
		if (got.soc_percent !== want.soc_percent)
			report_mismatch("soc_percent", int'(got.soc_percent),
				int'(want.soc_percent));
		if (got.battery_error !== want.battery_error)
			report_mismatch("battery_error", int'(got.battery_error),
				int'(want.battery_error));
		if (got.average_mv !== want.average_mv)
			report_mismatch("average_mv", int'(got.average_mv), int'(want.average_mv));
	endtask
endclass

module testbench;

	localparam int HALF_PERIOD   = 5;
	localparam int SETTLE_CYCLES = 200;      // longer than the slowest sample
	localparam int LIMIT_CYCLES  = 3000000;
	localparam int BLOCK_WORDS   = 24;       // words aimed at one voltage level
	localparam int RANDOM_PHASES = 1;

	typedef enum int {
		SHAPE_RAMP,    // rising table with a little jitter
		SHAPE_STEPS    // few distinct levels, unordered, many ties
	} ocv_shape_e;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_word_t   in_word;
	logic       out_valid;
	logic       out_ready;
	out_word_t  out_word;
	logic       cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	soc_scoreboard sb = new();

	// settings currently in the block, used to aim samples at a cell voltage
	int cur_gain;
	int cur_cells;
	// no idling on either side while set
	bit quiet;
	int phases_run;

	battery_soc_estimator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// mostly back-to-back, sometimes a short gap, now and then a long gap
	function automatic int idle_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic in_word_t sample_word(input logic [11:0] adc, input logic busy);
		in_word_t w;
		w.kind        = KIND_SAMPLE;
		w.adc_sample  = adc;
		w.motor_busy  = busy;
		w.table_index = 7'($urandom);   // don't-care fields still toggle
		w.table_value = 16'($urandom);
		return w;
	endfunction

	function automatic in_word_t table_word(input int idx, input int mv);
		in_word_t w;
		w.kind        = KIND_TABLE;
		w.adc_sample  = 12'($urandom);
		w.motor_busy  = 1'($urandom);
		w.table_index = idx[6:0];
		w.table_value = (mv > 65535) ? 16'hFFFF : mv[15:0];
		return w;
	endfunction

	// raw code that lands a sample near the given cell voltage
	function automatic logic [11:0] adc_for(input int cell_mv);
		longint pack_mv, code;
		if (cur_gain == 0)
			return 12'($urandom);
		pack_mv = longint'(cell_mv) * ((cur_cells == 0) ? 1 : cur_cells);
		code    = (pack_mv * 256) / cur_gain;
		if (code > 4095)
			code = 4095;
		return code[11:0];
	endfunction

	// one input word; valid stays up across back-to-back words
	task automatic send_word(input in_word_t w);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(w);
	endtask

	// sender holds off until every outstanding result word is back
	task automatic hold_until_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// idle block: nothing owed, and dropped words have surely finished too
	task automatic settle();
		hold_until_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// One register setting: program it, load a full OCV table, then run
	// blocks of samples aimed at voltage levels around the table span.
	task automatic run_phase(input int gain, input int cells, input int over_mv,
			input int under_mv, input bit chk_en, input ocv_shape_e shape,
			input int lo_mv, input int hi_mv, input int n_items, input bit directed);
		int i, k, cnt, r, target, span, val;
		logic [31:0] pad;
		bit paused;
		settle();
		cur_gain  = gain;
		cur_cells = cells & 15;
		quiet     = ($urandom_range(0, 3) == 0);
		pad       = $urandom;
		// unused upper bits of the narrow registers carry junk
		cfg_write(REG_SCALE_GAIN, gain[15:0]);
		cfg_write(REG_CELL_COUNT, (pad[15:0] & 16'hFFF0) | cells[3:0]);
		cfg_write(REG_CELL_OVER, (over_mv < 0) ? 16'd0 : over_mv[15:0]);
		cfg_write(REG_CELL_UNDER, (under_mv < 0) ? 16'd0 : under_mv[15:0]);
		cfg_write(REG_ERR_CHECK_EN, (pad[31:16] & 16'hFFFE) | chk_en);
		cfg_we <= 1'b0;

		// every entry written before the first sample of the phase
		span = (hi_mv > lo_mv) ? hi_mv - lo_mv : 1;
		for (i = 0; i < TABLE_ENTRIES_DEF; i++) begin
			if (shape == SHAPE_RAMP)
				val = lo_mv + span * i / (TABLE_ENTRIES_DEF - 1) + $urandom_range(0, span / 200);
			else
				val = lo_mv + (span / 8) * $urandom_range(0, 8);
			send_word(table_word(i, val));
		end

		if (directed) begin
			// writes past the table end are dropped
			send_word(table_word(127, 65535));
			send_word(table_word(TABLE_ENTRIES_DEF, 0));
			// motor busy: dropped whatever the code
			send_word(sample_word(12'hFFF, 1'b1));
			send_word(sample_word(12'h000, 1'b1));
			// first average window: zero average until it closes, then full
			// scale and zero codes mixed
			for (k = 0; k < AVG_COUNT_DEF; k++)
				send_word(sample_word(k[0] ? 12'hFFF : 12'h000, 1'b0));
		end

		cnt    = 0;
		paused = 0;
		while (cnt < n_items) begin
			target = lo_mv - span / 4 + $urandom_range(0, span * 3 / 2);
			if (target < 0)
				target = 0;
			for (k = 0; k < BLOCK_WORDS && cnt < n_items; k++) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					send_word(sample_word(12'($urandom), 1'b1));
				else if (r < 11)
					send_word(table_word($urandom_range(0, 127),
						lo_mv + $urandom_range(0, span)));
				else if (r < 16)
					send_word(sample_word(12'($urandom), 1'b0));
				else
					send_word(sample_word(adc_for(target + $urandom_range(0, span / 50)), 1'b0));
				cnt++;
			end
			if (!paused && cnt >= n_items / 2) begin
				hold_until_idle();
				paused = 1;
			end
		end
		phases_run++;
	endtask

	// result side: random back-pressure, every word checked in order
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_len();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_result(out_word);
		end
	end

	// stimulus
	initial begin
		int p, gain, cells, top, lo, hi, m, under, over, tmp;
		in_valid   = 1'b0;
		in_word    = '0;
		cfg_we     = 1'b0;
		cfg_index  = REG_SCALE_GAIN;
		cfg_data   = '0;
		quiet      = 1'b0;
		phases_run = 0;
		cur_gain   = int'(RST_SCALE_GAIN);
		cur_cells  = int'(RST_CELL_COUNT);
		wait (arst_n === 1'b1);
		@(posedge clk);

		// reset limits with the error check off: many readings implausible,
		// flag must stay clear
		run_phase(256, 6, 2500, 1500, 1'b0, SHAPE_RAMP, 1500, 2500, 60, 1'b1);
		// limits wider than the table, error check still off
		run_phase(1800, 6, 4300, 2800, 1'b0, SHAPE_RAMP, 3000, 4200, 60, 1'b0);
		// check on, staircase table for tie breaking
		run_phase(1024, 4, 4000, 3000, 1'b1, SHAPE_STEPS, 3100, 3900, 60, 1'b0);
		// zero gain: average always zero
		run_phase(0, 1, 65535, 0, 1'b1, SHAPE_RAMP, 0, 65535, 30, 1'b0);
		// top gain, saturated scaling, twelve cells
		run_phase(65535, 12, 65535, 0, 1'b1, SHAPE_RAMP, 100, 5400, 50, 1'b0);
		// cell count zero behaves as one
		run_phase(300, 0, 4500, 500, 1'b1, SHAPE_RAMP, 1000, 4000, 50, 1'b0);
		// cell count beyond the nominal range
		run_phase(4000, 15, 4200, 1800, 1'b1, SHAPE_STEPS, 2000, 4000, 50, 1'b0);
		// single cell, table over the whole 16-bit range
		run_phase(4096, 1, 65535, 0, 1'b0, SHAPE_RAMP, 0, 65535, 50, 1'b0);

		// random settings, sometimes with the limits swapped
		for (p = 0; p < RANDOM_PHASES; p++) begin
			gain  = $urandom_range(512, 4096);
			cells = $urandom_range(1, 12);
			top   = (4095 * gain) >> 8;
			if (top > 65535)
				top = 65535;
			top   = top / cells;
			lo    = top / 4;
			hi    = top * 3 / 4;
			m     = (hi - lo) / 10;
			under = lo - m;
			over  = hi + m;
			if ($urandom_range(0, 3) == 0) begin
				tmp   = under;
				under = over;
				over  = tmp;
			end
			run_phase(gain, cells, over, under, 1'($urandom_range(0, 1)),
				ocv_shape_e'($urandom_range(0, 1)), lo, hi, 50, 1'b0);
		end

		settle();
		$display("Ran %0d register settings, %0d result words checked, %0d words dropped.",
			phases_run, sb.checked, sb.n_dropped);
		$display("SOC paths: zero avg %0d, implausible %0d, low clamp %0d, high clamp %0d, nearest %0d.",
			sb.n_zero, sb.n_implausible, sb.n_low, sb.n_high, sb.n_nearest);
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Timeout with %0d result words outstanding", sb.pending());
		$display("Test completed with failures");
		$finish;
	end

endmodule
